// File: rtl/rti_pkg.sv
// Shared types, constants and saturation helpers for the ray/triangle hit block.
`timescale 1ns / 1ps
package rti_pkg;

  localparam int MAX_TRIANGLES = 65536;
  localparam int IDX_W         = 16;
  localparam int DIR_W         = 18;
  localparam int DIST_W        = 31;
  localparam int DIV_STEPS     = 31;
  localparam int ADDR_W        = 5;

  // register map, byte address = 4 * index
  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] REG_DIR_X     = 3'd3;
  localparam logic [2:0] REG_DIR_Y     = 3'd4;
  localparam logic [2:0] REG_DIR_Z     = 3'd5;
  localparam logic [2:0] REG_MAX_DIST  = 3'd6;

  localparam logic signed [DIR_W-1:0] DIR_Z_RESET    = 18'sd65536;
  localparam logic [DIST_W-1:0]       MAX_DIST_RESET = 31'h7FFF_FFFF;
  localparam logic signed [33:0]      ONE_Q16        = 34'sd65536;

  // projection plane codes
  localparam logic [1:0] PL_XY = 2'd0;
  localparam logic [1:0] PL_XZ = 2'd1;
  localparam logic [1:0] PL_YZ = 2'd2;

  typedef struct packed {
    logic signed [31:0] vertex_a_x;
    logic signed [31:0] vertex_a_y;
    logic signed [31:0] vertex_a_z;
    logic signed [31:0] vertex_b_x;
    logic signed [31:0] vertex_b_y;
    logic signed [31:0] vertex_b_z;
    logic signed [31:0] vertex_c_x;
    logic signed [31:0] vertex_c_y;
    logic signed [31:0] vertex_c_z;
    logic               last_triangle;
  } rti_in_t;

  typedef struct packed {
    logic               hit_found;
    logic [IDX_W-1:0]   hit_index;
    logic signed [31:0] hit_point_x;
    logic signed [31:0] hit_point_y;
    logic signed [31:0] hit_point_z;
    logic signed [31:0] weight_first;
    logic signed [31:0] weight_second;
    logic signed [31:0] weight_third;
    logic [DIST_W-1:0]  hit_distance;
  } rti_out_t;

  typedef struct packed {
    logic signed [31:0]      origin_x;
    logic signed [31:0]      origin_y;
    logic signed [31:0]      origin_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [DIST_W-1:0]       max_dist;
  } rti_cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] rem;
    logic [63:0] den;
    logic [30:0] low;
  } rti_div_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] quo;
  } rti_div_rsp_t;

  // clamp to +-(2^31-1)
  function automatic logic signed [31:0] symsat64(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh7FFF_FFFF) r = 32'sh8000_0001;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] symsat33(input logic signed [32:0] x);
    return symsat64({{31{x[32]}}, x});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

endpackage

// File: rtl/rti_mul.sv
// Shared 32x32 signed multiplier with registered product.
`timescale 1ns / 1ps
module rti_mul import rti_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// File: rtl/rti_div.sv
// Shared restoring divider: one quotient bit per cycle, saturates at 2^31-1.
`timescale 1ns / 1ps
module rti_div import rti_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  rti_div_req_t req,
  output rti_div_rsp_t rsp
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] den_r;
  logic [30:0] low_r;
  logic [30:0] quo_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] trial;
  logic        ge;

  assign trial   = {rem_r, low_r[30]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? 64'(trial - {1'b0, den_r}) : trial[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        // quotient would not fit in 31 bits
        if (req.rem >= req.den) begin
          quo_r  <= '1;
          done_r <= 1'b1;
        end else begin
          rem_r  <= req.rem;
          den_r  <= req.den;
          low_r  <= req.low;
          cnt_r  <= '0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[29:0], ge};
        low_r <= {low_r[29:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// File: rtl/rti_engine.sv
// Per-triangle sequencer: normal, plane distance, hit point, weights, nearest-hit tracking.
`timescale 1ns / 1ps
module rti_engine import rti_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rti_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  rti_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rti_out_t out_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CROSS = 4'd1;
  localparam logic [3:0] S_DOT   = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_DDIST = 4'd4;
  localparam logic [3:0] S_PT    = 4'd5;
  localparam logic [3:0] S_BARY  = 4'd6;
  localparam logic [3:0] S_SGN   = 4'd7;
  localparam logic [3:0] S_DA    = 4'd8;
  localparam logic [3:0] S_DB    = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_r;
  logic [2:0] step_r;

  rti_in_t            tri_r;
  logic signed [31:0] ab_r [3];
  logic signed [31:0] ac_r [3];
  logic signed [31:0] oa_r [3];
  logic signed [63:0] dyz_r, dxz_r, dxy_r;
  logic signed [63:0] acc_r, orient_r, s_r, na_r, nb_r;
  logic [30:0]        dist_r, wa_r;
  logic signed [31:0] pt_r [3];
  logic signed [31:0] ap_r [3];
  logic [1:0]         plane_r;

  logic [IDX_W-1:0]   cnt_r;
  logic [30:0]        best_dist_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic               best_found_r;
  logic signed [31:0] best_pt_r [3];
  logic signed [31:0] best_w_r [3];
  logic               query_open_r;
  logic               out_valid_r;
  rti_out_t           out_r;

  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] va [3];
  logic signed [31:0] vb [3];
  logic signed [31:0] vc [3];
  logic signed [31:0] nrm [3];

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  rti_div_req_t       div_req;
  rti_div_rsp_t       div_rsp;

  logic signed [31:0] abu, abw, acu, acw, apu, apw;
  logic signed [63:0] det;
  logic [1:0]         plane_sel;
  logic               plane_ok;
  logic               sign_ok;
  logic [1:0]         k_pt;
  logic signed [63:0] pt_sum;
  logic signed [31:0] pt_new;
  logic signed [33:0] wc;
  logic               load_out;

  assign org[0] = cfg.origin_x;
  assign org[1] = cfg.origin_y;
  assign org[2] = cfg.origin_z;
  assign dir[0] = 32'(cfg.dir_x);
  assign dir[1] = 32'(cfg.dir_y);
  assign dir[2] = 32'(cfg.dir_z);

  assign va[0] = tri_r.vertex_a_x;
  assign va[1] = tri_r.vertex_a_y;
  assign va[2] = tri_r.vertex_a_z;
  assign vb[0] = in_data.vertex_b_x;
  assign vb[1] = in_data.vertex_b_y;
  assign vb[2] = in_data.vertex_b_z;
  assign vc[0] = in_data.vertex_c_x;
  assign vc[1] = in_data.vertex_c_y;
  assign vc[2] = in_data.vertex_c_z;

  // normal from the raw cross products, floor shift then clamp
  assign nrm[0] = symsat64(dyz_r >>> 16);
  assign nrm[1] = symsat64((-dxz_r) >>> 16);
  assign nrm[2] = symsat64(dxy_r >>> 16);

  rti_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  rti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // projection plane choice
  always_comb begin
    plane_ok  = 1'b1;
    plane_sel = PL_XY;
    if (dxy_r != 0 && ac_r[1] != 0) plane_sel = PL_XY;
    else if (dxz_r != 0 && ac_r[2] != 0) plane_sel = PL_XZ;
    else if (dxy_r != 0) plane_sel = PL_XY;
    else if (dxz_r != 0) plane_sel = PL_XZ;
    else if (dyz_r != 0) plane_sel = PL_YZ;
    else plane_ok = 1'b0;
  end

  always_comb begin
    case (plane_r)
      PL_XY: begin
        abu = ab_r[0]; abw = ab_r[1]; acu = ac_r[0]; acw = ac_r[1];
        apu = ap_r[0]; apw = ap_r[1]; det = dxy_r;
      end
      PL_XZ: begin
        abu = ab_r[0]; abw = ab_r[2]; acu = ac_r[0]; acw = ac_r[2];
        apu = ap_r[0]; apw = ap_r[2]; det = dxz_r;
      end
      default: begin
        abu = ab_r[1]; abw = ab_r[2]; acu = ac_r[1]; acw = ac_r[2];
        apu = ap_r[1]; apw = ap_r[2]; det = dyz_r;
      end
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_CROSS: begin
        case (step_r)
          3'd0: begin mul_a = ab_r[1]; mul_b = ac_r[2]; end
          3'd1: begin mul_a = ab_r[2]; mul_b = ac_r[1]; end
          3'd2: begin mul_a = ab_r[0]; mul_b = ac_r[2]; end
          3'd3: begin mul_a = ab_r[2]; mul_b = ac_r[0]; end
          3'd4: begin mul_a = ab_r[0]; mul_b = ac_r[1]; end
          3'd5: begin mul_a = ab_r[1]; mul_b = ac_r[0]; end
          default: ;
        endcase
      end
      S_DOT: begin
        case (step_r)
          3'd0: begin mul_a = dir[0]; mul_b = nrm[0]; end
          3'd1: begin mul_a = dir[1]; mul_b = nrm[1]; end
          3'd2: begin mul_a = dir[2]; mul_b = nrm[2]; end
          3'd3: begin mul_a = oa_r[0]; mul_b = nrm[0]; end
          3'd4: begin mul_a = oa_r[1]; mul_b = nrm[1]; end
          3'd5: begin mul_a = oa_r[2]; mul_b = nrm[2]; end
          default: ;
        endcase
      end
      S_PT: begin
        mul_a = {1'b0, dist_r};
        case (step_r)
          3'd0: mul_b = dir[0];
          3'd1: mul_b = dir[1];
          3'd2: mul_b = dir[2];
          default: mul_b = '0;
        endcase
      end
      S_BARY: begin
        case (step_r)
          3'd0: begin mul_a = apu; mul_b = acw; end
          3'd1: begin mul_a = apw; mul_b = acu; end
          3'd2: begin mul_a = abu; mul_b = apw; end
          3'd3: begin mul_a = abw; mul_b = apu; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign sign_ok = !((na_r != 0 && (na_r[63] != det[63])) ||
                     (nb_r != 0 && (nb_r[63] != det[63])));

  // divider requests: distance, then weight a, then weight b
  always_comb begin
    logic [63:0] mn;
    mn            = mag64(state_r == S_DA ? nb_r : na_r);
    div_req.start = 1'b0;
    div_req.rem   = mn >> 15;
    div_req.den   = mag64(det);
    div_req.low   = {mn[14:0], 16'b0};
    case (state_r)
      S_CHK: begin
        div_req.start = !(orient_r >= 0 || s_r < 0);
        div_req.rem   = 64'(s_r <<< 1);
        div_req.den   = 64'(-orient_r);
        div_req.low   = '0;
      end
      S_SGN:   div_req.start = sign_ok;
      S_DA:    div_req.start = div_rsp.done;
      default: ;
    endcase
  end

  // hit point for the component whose product is arriving
  always_comb begin
    case (step_r)
      3'd1:    k_pt = 2'd0;
      3'd2:    k_pt = 2'd1;
      default: k_pt = 2'd2;
    endcase
    pt_sum = 64'(org[k_pt]) + (prod >>> 16);
    pt_new = sat32(pt_sum);
  end

  assign wc = ONE_Q16 - 34'(signed'({3'b0, wa_r})) - 34'(signed'({3'b0, div_rsp.quo}));

  // result register loads on the closing triangle once it is free
  assign load_out = (state_r == S_FIN) && tri_r.last_triangle && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      cnt_r        <= '0;
      best_found_r <= 1'b0;
      best_idx_r   <= '0;
      query_open_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !load_out) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            tri_r <= in_data;
            ab_r[0] <= symsat33(33'(vb[0]) - 33'(in_data.vertex_a_x));
            ab_r[1] <= symsat33(33'(vb[1]) - 33'(in_data.vertex_a_y));
            ab_r[2] <= symsat33(33'(vb[2]) - 33'(in_data.vertex_a_z));
            ac_r[0] <= symsat33(33'(vc[0]) - 33'(in_data.vertex_a_x));
            ac_r[1] <= symsat33(33'(vc[1]) - 33'(in_data.vertex_a_y));
            ac_r[2] <= symsat33(33'(vc[2]) - 33'(in_data.vertex_a_z));
            oa_r[0] <= symsat33(33'(org[0]) - 33'(in_data.vertex_a_x));
            oa_r[1] <= symsat33(33'(org[1]) - 33'(in_data.vertex_a_y));
            oa_r[2] <= symsat33(33'(org[2]) - 33'(in_data.vertex_a_z));
            if (!query_open_r) begin
              best_dist_r  <= cfg.max_dist;
              query_open_r <= 1'b1;
            end
            step_r  <= '0;
            state_r <= S_CROSS;
          end
        end
        S_CROSS: begin
          case (step_r)
            3'd1, 3'd3, 3'd5: acc_r <= prod;
            3'd2: dyz_r <= acc_r - prod;
            3'd4: dxz_r <= acc_r - prod;
            3'd6: dxy_r <= acc_r - prod;
            default: ;
          endcase
          if (step_r == 3'd6) begin
            step_r   <= '0;
            orient_r <= '0;
            s_r      <= '0;
            state_r  <= S_DOT;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_DOT: begin
          if (step_r >= 3'd1 && step_r <= 3'd3) orient_r <= orient_r + prod;
          if (step_r >= 3'd4) s_r <= s_r + (prod >>> 16);
          if (step_r == 3'd6) state_r <= S_CHK;
          else step_r <= step_r + 3'd1;
        end
        S_CHK: begin
          if (orient_r >= 0 || s_r < 0) state_r <= S_FIN;
          else state_r <= S_DDIST;
        end
        S_DDIST: begin
          if (div_rsp.done) begin
            dist_r <= div_rsp.quo;
            step_r <= '0;
            if (div_rsp.quo >= best_dist_r) state_r <= S_FIN;
            else state_r <= S_PT;
          end
        end
        S_PT: begin
          if (step_r != 3'd0) begin
            pt_r[k_pt] <= pt_new;
            ap_r[k_pt] <= symsat64(64'(pt_new) - 64'(va[k_pt]));
          end
          if (step_r == 3'd3) begin
            plane_r <= plane_sel;
            step_r  <= '0;
            state_r <= plane_ok ? S_BARY : S_FIN;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_BARY: begin
          case (step_r)
            3'd1, 3'd3: acc_r <= prod;
            3'd2: nb_r <= acc_r - prod;
            3'd4: na_r <= acc_r - prod;
            default: ;
          endcase
          if (step_r == 3'd4) state_r <= S_SGN;
          else step_r <= step_r + 3'd1;
        end
        S_SGN: begin
          state_r <= sign_ok ? S_DA : S_FIN;
        end
        S_DA: begin
          if (div_rsp.done) begin
            wa_r    <= div_rsp.quo;
            state_r <= S_DB;
          end
        end
        S_DB: begin
          if (div_rsp.done) begin
            if (!wc[33]) begin
              best_dist_r  <= dist_r;
              best_idx_r   <= cnt_r;
              best_found_r <= 1'b1;
              best_pt_r    <= pt_r;
              best_w_r[0]  <= wc[31:0];
              best_w_r[1]  <= {1'b0, div_rsp.quo};
              best_w_r[2]  <= {1'b0, wa_r};
            end
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!tri_r.last_triangle) begin
            cnt_r   <= (cnt_r == IDX_W'(MAX_TRIANGLES - 1)) ? '0 : cnt_r + 1'b1;
            state_r <= S_IDLE;
          end else if (load_out) begin
            out_r.hit_found     <= best_found_r;
            out_r.hit_index     <= best_found_r ? best_idx_r : '0;
            out_r.hit_point_x   <= best_found_r ? best_pt_r[0] : '0;
            out_r.hit_point_y   <= best_found_r ? best_pt_r[1] : '0;
            out_r.hit_point_z   <= best_found_r ? best_pt_r[2] : '0;
            out_r.weight_first  <= best_found_r ? best_w_r[0] : '0;
            out_r.weight_second <= best_found_r ? best_w_r[1] : '0;
            out_r.weight_third  <= best_found_r ? best_w_r[2] : '0;
            out_r.hit_distance  <= best_found_r ? best_dist_r : '0;
            out_valid_r  <= 1'b1;
            cnt_r        <= '0;
            best_found_r <= 1'b0;
            best_idx_r   <= '0;
            query_open_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/ray_triangle_nearest_hit.sv
// Top level: APB register file for the ray and the triangle test engine.
`timescale 1ns / 1ps
// Streams triangles (Q16.16 vertices) against one ray held in registers and
// reports the nearest front-facing hit when the word flagged last_triangle
// is done. One triangle is handled at a time on a shared 32x32 multiplier and
// a one-bit-per-cycle divider. A full hit is dominated by three 31-step
// divisions (distance, two barycentric weights); back-facing or behind-origin
// triangles leave at the dot-product sign check, farther ones after the
// distance division. in_ready is high only between triangles. A finished
// result waits in the output register while the next query's triangles are
// taken. The direction must be unit length; it is not normalized.
module ray_triangle_nearest_hit import rti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rti_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rti_out_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  rti_cfg_t   cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.origin_z <= '0;
      cfg_r.dir_x    <= '0;
      cfg_r.dir_y    <= '0;
      cfg_r.dir_z    <= DIR_Z_RESET;
      cfg_r.max_dist <= MAX_DIST_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ORIGIN_X: cfg_r.origin_x <= cfg_pwdata;
        REG_ORIGIN_Y: cfg_r.origin_y <= cfg_pwdata;
        REG_ORIGIN_Z: cfg_r.origin_z <= cfg_pwdata;
        REG_DIR_X:    cfg_r.dir_x    <= cfg_pwdata[DIR_W-1:0];
        REG_DIR_Y:    cfg_r.dir_y    <= cfg_pwdata[DIR_W-1:0];
        REG_DIR_Z:    cfg_r.dir_z    <= cfg_pwdata[DIR_W-1:0];
        REG_MAX_DIST: cfg_r.max_dist <= cfg_pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X: cfg_prdata = cfg_r.origin_x;
      REG_ORIGIN_Y: cfg_prdata = cfg_r.origin_y;
      REG_ORIGIN_Z: cfg_prdata = cfg_r.origin_z;
      REG_DIR_X:    cfg_prdata = 32'(cfg_r.dir_x);
      REG_DIR_Y:    cfg_prdata = 32'(cfg_r.dir_y);
      REG_DIR_Z:    cfg_prdata = 32'(cfg_r.dir_z);
      REG_MAX_DIST: cfg_prdata = {1'b0, cfg_r.max_dist};
      default:      cfg_prdata = '0;
    endcase
  end

  rti_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
